>>> src/stack_permutation_checker_defines.svh
// Assertion macros used by the checker's top-level RTL file.
`ifndef STACK_PERMUTATION_CHECKER_DEFINES_SVH
`define STACK_PERMUTATION_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SPC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/spc_pkg.sv
package spc_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CAR_BITS = 16;

	localparam int CAP_BITS = 6;
	localparam int LEN_BITS = 16;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = (CAP_BITS > LEN_BITS) ? CAP_BITS : LEN_BITS;

	localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int NA_BITS = CAR_BITS + 1;
	localparam int CMP_BITS = ((CAR_BITS > CNT_BITS) ? CAR_BITS : CNT_BITS) + 2;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(32);
	localparam logic [LEN_BITS-1:0] LEN_RESET = '1;

	localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH = CFG_IDX_BITS'(1);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP = 1'b1;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_BELOW = 3'd1,
		ERR_OVERFLOW = 3'd2,
		ERR_DUP = 3'd3,
		ERR_FAILED = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANGE,
		S_TOP,
		S_ARRIVE,
		S_CAP,
		S_PUSH,
		S_POP
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

	typedef struct packed {
		logic en;
		logic [ADDR_BITS-1:0] addr;
		logic [CAR_BITS-1:0] data;
	} stk_wr_t;

endpackage

>>> src/spc_cmp.sv
module spc_cmp import spc_pkg::*; (
	input logic [CMP_BITS-1:0] a,
	input logic [CMP_BITS-1:0] b,
	output cmp_res_t res
);

	assign res.lt = (a < b);
	assign res.eq = (a == b);

endmodule

>>> src/spc_stack.sv
module spc_stack import spc_pkg::*; (
	input logic clk,
	input stk_wr_t wr,
	input logic [ADDR_BITS-1:0] rd_addr,
	output logic [CAR_BITS-1:0] rd_data
);

	logic [CAR_BITS-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> src/stack_permutation_checker.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  car, first
// res       out        res_valid/res_stall  op, moved_car, error, last
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request is taken in the idle state and then checked through the shared comparator in the
// range, top, arrival and capacity steps (top only with a non-empty stack); an error result leaves
// from the check step that finds it. A passing car yields a push for each waiting car below it,
// then a push and a pop of itself; a car equal to the stack top yields a single pop. The request
// is stalled until the last result is loaded into the output register.
// Reset sets capacity to 32, length to 65535 and empties the stack.
// A stalled result holds the sequencer in any step that emits a result.
`include "stack_permutation_checker_defines.svh"

module stack_permutation_checker import spc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [CAR_BITS-1:0] car,
	input logic first,
	output logic res_valid,
	input logic res_stall,
	output logic op,
	output logic [CAR_BITS-1:0] moved_car,
	output logic [2:0] error,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [CAP_BITS-1:0] capacity_q;
	logic [LEN_BITS-1:0] length_q;
	logic [CAR_BITS-1:0] car_q;
	logic [CNT_BITS-1:0] held_count_q;
	logic [NA_BITS-1:0] next_arrival_q;
	logic failed_q;

	logic res_valid_q;
	logic op_q;
	logic [CAR_BITS-1:0] moved_q;
	err_t error_q;
	logic last_q;

	logic [CAP_BITS-1:0] cap_eff;
	logic [CMP_BITS-1:0] need_sum;
	logic [CMP_BITS-1:0] cmp_a, cmp_b;
	cmp_res_t cmp;
	logic [CAR_BITS-1:0] top_car;
	stk_wr_t stk_wr;
	logic [ADDR_BITS-1:0] rd_addr;

	logic accept;
	logic can_emit;
	logic emit;
	logic e_op;
	logic [CAR_BITS-1:0] e_car;
	err_t e_err;
	logic e_last;
	logic set_fail;
	logic do_pop;
	logic do_push;
	logic pass_done;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;
	assign can_emit = !res_valid_q || !res_stall;

	assign cap_eff = (capacity_q < CAP_BITS'(STACK_DEPTH)) ? capacity_q : CAP_BITS'(STACK_DEPTH);
	assign need_sum = CMP_BITS'(held_count_q) + CMP_BITS'(car_q) - CMP_BITS'(next_arrival_q)
		+ CMP_BITS'(1);

	always_comb begin
		case (state_q)
			S_RANGE: begin
				cmp_a = CMP_BITS'(length_q);
				cmp_b = CMP_BITS'(car_q);
			end
			S_TOP: begin
				cmp_a = CMP_BITS'(car_q);
				cmp_b = CMP_BITS'(top_car);
			end
			S_ARRIVE: begin
				cmp_a = CMP_BITS'(car_q);
				cmp_b = CMP_BITS'(next_arrival_q);
			end
			S_CAP: begin
				cmp_a = CMP_BITS'(cap_eff);
				cmp_b = need_sum;
			end
			S_PUSH: begin
				cmp_a = CMP_BITS'(next_arrival_q);
				cmp_b = CMP_BITS'(car_q);
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end

	spc_cmp u_cmp (
		.a(cmp_a),
		.b(cmp_b),
		.res(cmp)
	);

	assign rd_addr = ADDR_BITS'(held_count_q - CNT_BITS'(1));
	assign stk_wr.en = do_push;
	assign stk_wr.addr = ADDR_BITS'(held_count_q);
	assign stk_wr.data = next_arrival_q[CAR_BITS-1:0];

	spc_stack u_stack (
		.clk(clk),
		.wr(stk_wr),
		.rd_addr(rd_addr),
		.rd_data(top_car)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		e_op = OP_PUSH;
		e_car = '0;
		e_err = ERR_NONE;
		e_last = 1'b0;
		set_fail = 1'b0;
		do_pop = 1'b0;
		do_push = 1'b0;
		pass_done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_RANGE;
				end
			end
			S_RANGE: begin
				if (failed_q) begin
					emit = 1'b1;
					e_err = ERR_FAILED;
					e_last = 1'b1;
					if (can_emit) begin
						state_d = S_IDLE;
					end
				end else if ((car_q == '0) || cmp.lt) begin
					emit = 1'b1;
					e_err = ERR_DUP;
					e_last = 1'b1;
					if (can_emit) begin
						set_fail = 1'b1;
						state_d = S_IDLE;
					end
				end else if (held_count_q != '0) begin
					state_d = S_TOP;
				end else begin
					state_d = S_ARRIVE;
				end
			end
			S_TOP: begin
				if (cmp.lt) begin
					emit = 1'b1;
					e_err = ERR_BELOW;
					e_last = 1'b1;
					if (can_emit) begin
						set_fail = 1'b1;
						state_d = S_IDLE;
					end
				end else if (cmp.eq) begin
					emit = 1'b1;
					e_op = OP_POP;
					e_car = car_q;
					e_last = 1'b1;
					if (can_emit) begin
						do_pop = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_ARRIVE;
				end
			end
			S_ARRIVE: begin
				if (cmp.lt) begin
					emit = 1'b1;
					e_err = ERR_DUP;
					e_last = 1'b1;
					if (can_emit) begin
						set_fail = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_CAP;
				end
			end
			S_CAP: begin
				if (cmp.lt) begin
					emit = 1'b1;
					e_err = ERR_OVERFLOW;
					e_last = 1'b1;
					if (can_emit) begin
						set_fail = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				emit = 1'b1;
				if (cmp.lt) begin
					e_car = next_arrival_q[CAR_BITS-1:0];
					if (can_emit) begin
						do_push = 1'b1;
					end
				end else begin
					e_car = car_q;
					if (can_emit) begin
						state_d = S_POP;
					end
				end
			end
			S_POP: begin
				emit = 1'b1;
				e_op = OP_POP;
				e_car = car_q;
				e_last = 1'b1;
				if (can_emit) begin
					pass_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			length_q <= LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAPACITY: capacity_q <= cfg_data[CAP_BITS-1:0];
				REG_LENGTH: length_q <= cfg_data[LEN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			car_q <= car;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			next_arrival_q <= NA_BITS'(1);
			failed_q <= 1'b0;
		end else begin
			if (accept && first) begin
				held_count_q <= '0;
				next_arrival_q <= NA_BITS'(1);
				failed_q <= 1'b0;
			end
			if (set_fail) begin
				failed_q <= 1'b1;
			end
			if (do_pop) begin
				held_count_q <= held_count_q - CNT_BITS'(1);
			end
			if (do_push) begin
				held_count_q <= held_count_q + CNT_BITS'(1);
				next_arrival_q <= next_arrival_q + NA_BITS'(1);
			end
			if (pass_done) begin
				next_arrival_q <= NA_BITS'(car_q) + NA_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit && can_emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && can_emit) begin
			op_q <= e_op;
			moved_q <= e_car;
			error_q <= e_err;
			last_q <= e_last;
		end
	end

	assign res_valid = res_valid_q;
	assign op = op_q;
	assign moved_car = moved_q;
	assign error = error_q;
	assign last = last_q;

	`SPC_ASSERT(a_count_bound, 1'b1, held_count_q <= CNT_BITS'(STACK_DEPTH),
		"held count exceeds stack depth")
	`SPC_ASSERT(a_error_shape, res_valid && (error != ERR_NONE),
		last && (moved_car == '0) && (op == OP_PUSH), "error result is malformed")
	`SPC_ASSERT_NEXT(a_push_count, stk_wr.en,
		held_count_q == $past(held_count_q) + CNT_BITS'(1), "push did not grow the stack")
	`SPC_ASSERT(a_push_order, state_q == S_PUSH,
		next_arrival_q <= NA_BITS'(car_q), "next arrival passed the wanted car")

endmodule
